// ----- design/avba_pkg.sv -----
package avba_pkg;

  // Field widths
  localparam int unsigned CountW  = 6;
  localparam int unsigned AlignW  = 7;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned SpanW   = 7;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned DataW   = 13;
  localparam int unsigned StatusW = 2;
  localparam int unsigned StartW  = 8;   // search cursor, may step past the span
  localparam int unsigned SumW    = 9;   // cursor + count

  localparam int unsigned MaxVectorsDefault = 64;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_UNUSED   = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic {
    REG_SPAN   = 1'b0,
    REG_OFFSET = 1'b1
  } reg_index_t;

  // Result of the shared run unit
  typedef struct packed {
    logic fits;      // base + count stays within the limit
    logic free;      // no used bit under the run mask
    logic all_used;  // every bit under the run mask is used
  } run_status_t;

  function automatic logic is_pow2(input logic [AlignW-1:0] v);
    logic [AlignW-1:0] vm1;
    begin
      vm1 = v - AlignW'(1);
      return (v != '0) && ((v & vm1) == '0);
    end
  endfunction

endpackage

// ----- design/avba_run_unit.sv -----
module avba_run_unit #(
  parameter int unsigned MAX_VECTORS = avba_pkg::MaxVectorsDefault
) (
  input  logic [MAX_VECTORS-1:0]           used_map,
  input  logic [avba_pkg::StartW-1:0]      base,
  input  logic [avba_pkg::CountW-1:0]      count,
  input  logic [avba_pkg::SpanW-1:0]       limit,
  output logic [MAX_VECTORS-1:0]           mask,
  output avba_pkg::run_status_t            run
);

  logic [MAX_VECTORS-1:0]        ones;
  logic [MAX_VECTORS-1:0]        hit;
  logic [avba_pkg::SumW-1:0]     run_end;

  // count ones at the bottom; a count at or above the width wraps to all ones
  assign ones    = (MAX_VECTORS'(1) << count) - MAX_VECTORS'(1);
  assign mask    = ones << base;
  assign hit     = used_map & mask;
  assign run_end = avba_pkg::SumW'(base) + avba_pkg::SumW'(count);

  assign run.fits     = run_end <= avba_pkg::SumW'(limit);
  assign run.free     = hit == '0;
  assign run.all_used = hit == mask;

endmodule

// ----- design/aligned_vector_block_allocator.sv -----
// Aligned vector block allocator.
// Keeps one used bit per interrupt vector. Requests enter on the s_ stream
// (s_tuser = opcode: allocate or release); one result per request leaves on
// the m_ stream (m_tuser = status). The APB port holds vector_span (0x0)
// and data_offset (0x4); write them only while no request is in flight.
// Allocate: steps a cursor over aligned start positions, lowest first, one
// position per cycle through a single shift/mask/compare unit. The first
// free run that fits inside the span is marked used; first_index and
// msi_data (index + data_offset) come back with status ok.
// Release: one pass of the same unit clears the named run and flags any
// vector that was not in use (or lies beyond the map).
// An allocate tries at most span/alignment + 1 start positions; a release
// takes one release step; malformed requests go straight to the reply
// step. One request is in the block at a time: s_tready is high only
// while the sequencer is idle.
// A held result waits in the output register while m_tready is low; the
// sequencer parks in its reply step until the register is free.
// Reset (rst, synchronous) frees every vector, sets the span to 64 and the
// offset to 0, and drops any pending transaction.
module aligned_vector_block_allocator #(
  parameter int unsigned MAX_VECTORS = avba_pkg::MaxVectorsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // block_count[5:0], alignment[12:6],
                                                    // vector_index[18:13], zero fill
  input  logic [0:0]                      s_tuser,  // opcode[0]
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // first_index[5:0], msi_data[18:6],
                                                    // zero fill
  output logic [1:0]                      m_tuser,  // status[1:0]
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [avba_pkg::ApbAddrW-1:0]   paddr,
  input  logic [avba_pkg::ApbDataW-1:0]   pwdata,
  output logic [avba_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SEARCH  = 4'b0010,
    S_RELEASE = 4'b0100,
    S_REPLY   = 4'b1000
  } state_t;

  localparam logic [avba_pkg::SpanW-1:0] MapSpan = avba_pkg::SpanW'(MAX_VECTORS);

  state_t state;

  // configuration registers
  logic [avba_pkg::SpanW-1:0]   vector_span;
  logic [avba_pkg::OffsetW-1:0] data_offset;
  logic                         cfg_write;
  avba_pkg::reg_index_t         cfg_sel;

  // request fields
  logic [avba_pkg::CountW-1:0]   req_count;
  logic [avba_pkg::AlignW-1:0]   req_align;
  logic [avba_pkg::IndexW-1:0]   req_index;

  // working state
  logic [MAX_VECTORS-1:0]        used_map;
  logic [avba_pkg::StartW-1:0]   start;
  logic [avba_pkg::SpanW-1:0]    span_eff;

  // result held until the output register frees up
  avba_pkg::status_t             res_status;
  logic [avba_pkg::IndexW-1:0]   res_first;
  logic [avba_pkg::DataW-1:0]    res_data;

  // output register
  avba_pkg::status_t             out_status;
  logic [avba_pkg::IndexW-1:0]   out_first;
  logic [avba_pkg::DataW-1:0]    out_data;

  // shared run unit
  logic [avba_pkg::StartW-1:0]   unit_base;
  logic [avba_pkg::SpanW-1:0]    unit_limit;
  logic [MAX_VECTORS-1:0]        unit_mask;
  avba_pkg::run_status_t         unit_run;

  logic                          s_fire;
  logic                          out_free;
  logic                          in_opcode;
  logic [avba_pkg::CountW-1:0]   in_count;
  logic [avba_pkg::AlignW-1:0]   in_align;

  // ---------------------------------------------------------------------
  // APB: word addressed, register picked by paddr[2], always ready
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = avba_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_span <= avba_pkg::SpanW'(64);
      data_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        avba_pkg::REG_SPAN:   vector_span <= pwdata[avba_pkg::SpanW-1:0];
        avba_pkg::REG_OFFSET: data_offset <= pwdata[avba_pkg::OffsetW-1:0];
        default:              vector_span <= vector_span;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      avba_pkg::REG_SPAN:   prdata = avba_pkg::ApbDataW'(vector_span);
      avba_pkg::REG_OFFSET: prdata = avba_pkg::ApbDataW'(data_offset);
      default:              prdata = '0;
    endcase
  end

  // span beyond the map acts as the full map
  assign span_eff = (vector_span > MapSpan) ? MapSpan : vector_span;

  // ---------------------------------------------------------------------
  // Handshakes and request unpacking
  // ---------------------------------------------------------------------
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign in_opcode = s_tuser[0];
  assign in_count  = s_tdata[5:0];
  assign in_align  = s_tdata[12:6];

  // ---------------------------------------------------------------------
  // Shared unit: cursor during search, release index during release
  // ---------------------------------------------------------------------
  always_comb begin
    if (state == S_RELEASE) begin
      unit_base  = avba_pkg::StartW'(req_index);
      unit_limit = MapSpan;
    end else begin
      unit_base  = start;
      unit_limit = span_eff;
    end
  end

  avba_run_unit #(
    .MAX_VECTORS (MAX_VECTORS)
  ) u_run (
    .used_map (used_map),
    .base     (unit_base),
    .count    (req_count),
    .limit    (unit_limit),
    .mask     (unit_mask),
    .run      (unit_run)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used_map <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (avba_pkg::opcode_t'(in_opcode) == avba_pkg::OP_ALLOC) begin
              if (avba_pkg::is_pow2(avba_pkg::AlignW'(in_count)) &&
                  avba_pkg::is_pow2(in_align)) begin
                state <= S_SEARCH;
              end else begin
                state <= S_REPLY;
              end
            end else begin
              if (in_count != '0) begin
                state <= S_RELEASE;
              end else begin
                state <= S_REPLY;
              end
            end
          end
        end
        S_SEARCH: begin
          if (!unit_run.fits) begin
            state <= S_REPLY;
          end else if (unit_run.free) begin
            used_map <= used_map | unit_mask;
            state    <= S_REPLY;
          end
        end
        S_RELEASE: begin
          used_map <= used_map & ~unit_mask;
          state    <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request latch, cursor and held result (payload, no reset)
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          req_count  <= in_count;
          req_align  <= in_align;
          req_index  <= s_tdata[18:13];
          start      <= '0;
          res_status <= avba_pkg::ST_INVALID;
          res_first  <= '0;
          res_data   <= '0;
        end
      end
      S_SEARCH: begin
        if (!unit_run.fits) begin
          res_status <= avba_pkg::ST_NO_FREE;
        end else if (unit_run.free) begin
          res_status <= avba_pkg::ST_OK;
          res_first  <= start[avba_pkg::IndexW-1:0];
          res_data   <= avba_pkg::DataW'(start) + avba_pkg::DataW'(data_offset);
        end else begin
          start <= start + avba_pkg::StartW'(req_align);
        end
      end
      S_RELEASE: begin
        res_status <= (!unit_run.fits || !unit_run.all_used) ?
                      avba_pkg::ST_UNUSED : avba_pkg::ST_OK;
      end
      S_REPLY: begin
        res_status <= res_status;
      end
      default: res_status <= res_status;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_REPLY && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPLY && out_free) begin
      out_status <= res_status;
      out_first  <= res_first;
      out_data   <= res_data;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'b0, out_data, out_first};

endmodule
